// ----- sv/line_rasterizer_defines.svh -----
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared immediate-implication and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRAST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrast assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LRAST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrast assertion failed");

`endif

// ----- sv/lrast_pkg.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared constants, register and command codes, and control flag struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrast_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CLIP_BITS      = 15;

  localparam logic [CLIP_BITS-1:0] CLIP_W_RESET = 15'd1600;
  localparam logic [CLIP_BITS-1:0] CLIP_H_RESET = 15'd900;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 1'b1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef struct packed {
    logic busy;
    logic steep;
    logic minor_down;
  } lrast_ctrl_t;

endpackage

// ----- sv/line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer
// Bresenham line walker for all octants with clip flags, one pixel per word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes commands: tuser is func (start or step), tdata packs
//   x_start, y_start, x_end, y_end from the low bits up. A start word seeds a
//   line and yields its first pixel, each step word yields the next pixel.
//   Master stream gives one word per command: tdata packs pixel_x, pixel_y,
//   tuser packs pixel_valid, visible, tlast marks the line's final pixel.
//   A step with no active line yields pixel_valid 0 and zero fields.
//   Config channel writes clip_width (index 0) and clip_height (index 1);
//   write only while no command is in flight.
//   Each command passes through the input register into the result register;
//   throughput is one word per cycle unless the receiver stalls, bounded by
//   the combinational add and compare of the error update for the next step.
//   Reset drops any active line, empties both stages and restores the clip
//   window to 1600 by 900. When the receiver stalls, the result register
//   holds, the input register takes at most one more word, then tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer import lrast_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  // x_start, y_start, x_end, y_end
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata_i,
  // func
  input  logic                                  s_tuser_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  // pixel_x, pixel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata_o,
  // pixel_valid, visible
  output logic [1:0]                            m_tuser_o,
  output logic                                  m_tlast_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index_i,
  input  logic [CLIP_BITS-1:0]                  cfg_data_i
);

  localparam int CB     = COORD_BITS;
  localparam int EW     = COORD_BITS + 4;
  localparam int OUT_DW = ((2*COORD_BITS+7)/8)*8;

  logic [CLIP_BITS-1:0] clip_w_q, clip_h_q;

  logic                 in_valid_q;
  logic                 in_func_q;
  logic signed [CB-1:0] in_x0_q, in_y0_q, in_x1_q, in_y1_q;

  logic signed [CB-1:0] cur_x_q, cur_y_q, major_end_q;
  logic signed [EW-1:0] err_q;
  logic        [CB:0]   major_delta_q, minor_delta_q;
  lrast_ctrl_t          ctrl_q;

  logic signed [CB-1:0] cur_x_d, cur_y_d, major_end_d;
  logic signed [EW-1:0] err_d;
  logic        [CB:0]   major_delta_d, minor_delta_d;
  lrast_ctrl_t          ctrl_d;
  logic                 steep_d;

  logic                 out_valid_q, out_pv_q, out_vis_q, out_last_q;
  logic signed [CB-1:0] out_x_q, out_y_q;

  logic signed [CB-1:0] st_x, st_y, st_end;
  logic        [CB:0]   st_maj, st_min;
  logic signed [EW-1:0] st_err;
  logic                 st_steep, st_down;
  logic signed [CB-1:0] sp_x, sp_y;
  logic signed [EW-1:0] sp_err;
  logic                 is_start, do_step, pv, vis, last, advance;

  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= CLIP_W_RESET;
      clip_h_q <= CLIP_H_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLIP_WIDTH:  clip_w_q <= cfg_data_i;
        CFG_CLIP_HEIGHT: clip_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_func_q <= s_tuser_i;
      in_x0_q   <= s_tdata_i[0*CB +: CB];
      in_y0_q   <= s_tdata_i[1*CB +: CB];
      in_x1_q   <= s_tdata_i[2*CB +: CB];
      in_y1_q   <= s_tdata_i[3*CB +: CB];
    end
  end

  lrast_start #(.COORD_BITS(COORD_BITS)) u_start (
    .x_start_i     (in_x0_q),
    .y_start_i     (in_y0_q),
    .x_end_i       (in_x1_q),
    .y_end_i       (in_y1_q),
    .cur_x_o       (st_x),
    .cur_y_o       (st_y),
    .major_end_o   (st_end),
    .major_delta_o (st_maj),
    .minor_delta_o (st_min),
    .err_o         (st_err),
    .steep_o       (st_steep),
    .minor_down_o  (st_down)
  );

  lrast_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x_i       (cur_x_q),
    .cur_y_i       (cur_y_q),
    .err_i         (err_q),
    .major_delta_i (major_delta_q),
    .minor_delta_i (minor_delta_q),
    .ctrl_i        (ctrl_q),
    .cur_x_o       (sp_x),
    .cur_y_o       (sp_y),
    .err_o         (sp_err)
  );

  assign is_start = (in_func_q == FUNC_START);
  assign do_step  = (in_func_q == FUNC_STEP) && ctrl_q.busy;
  assign pv       = is_start || do_step;
  assign steep_d  = is_start ? st_steep : ctrl_q.steep;

  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    major_end_d   = major_end_q;
    err_d         = err_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    if (is_start) begin
      cur_x_d       = st_x;
      cur_y_d       = st_y;
      major_end_d   = st_end;
      err_d         = st_err;
      major_delta_d = st_maj;
      minor_delta_d = st_min;
    end else if (do_step) begin
      cur_x_d = sp_x;
      cur_y_d = sp_y;
      err_d   = sp_err;
    end
  end

  always_comb begin
    ctrl_d       = ctrl_q;
    ctrl_d.steep = steep_d;
    if (is_start) begin
      ctrl_d.minor_down = st_down;
    end
    if (pv) begin
      ctrl_d.busy = !last;
    end
  end

  lrast_emit #(.COORD_BITS(COORD_BITS)) u_emit (
    .cur_x_i       (cur_x_d),
    .cur_y_i       (cur_y_d),
    .major_end_i   (major_end_d),
    .steep_i       (steep_d),
    .clip_width_i  (clip_w_q),
    .clip_height_i (clip_h_q),
    .visible_o     (vis),
    .last_o        (last)
  );

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (advance) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      major_end_q   <= major_end_d;
      err_q         <= err_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pv_q   <= pv;
      out_x_q    <= pv ? cur_x_d : '0;
      out_y_q    <= pv ? cur_y_d : '0;
      out_vis_q  <= pv && vis;
      out_last_q <= pv && last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_DW'({out_y_q, out_x_q});
  assign m_tuser_o  = {out_vis_q, out_pv_q};
  assign m_tlast_o  = out_last_q;

endmodule

// ----- sv/lrast_start.sv -----
// ----------------------------------------------------------------------------
// Line setup
// Picks the major axis, orders the endpoints and seeds the error term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrast_start import lrast_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic signed [COORD_BITS-1:0] cur_x_o,
  output logic signed [COORD_BITS-1:0] cur_y_o,
  output logic signed [COORD_BITS-1:0] major_end_o,
  output logic        [COORD_BITS:0]   major_delta_o,
  output logic        [COORD_BITS:0]   minor_delta_o,
  output logic signed [COORD_BITS+3:0] err_o,
  output logic                         steep_o,
  output logic                         minor_down_o
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx, dy;
  logic        [DW-1:0] adx, ady;
  logic                 swap;
  logic                 dx_pos, dx_neg, dy_pos, dy_neg;

  assign dx  = DW'(x_end_i) - DW'(x_start_i);
  assign dy  = DW'(y_end_i) - DW'(y_start_i);
  assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);

  assign dx_neg = dx[DW-1];
  assign dx_pos = !dx[DW-1] && (dx != '0);
  assign dy_neg = dy[DW-1];
  assign dy_pos = !dy[DW-1] && (dy != '0);

  assign steep_o = !(ady < adx);
  assign swap    = steep_o ? (y_start_i > y_end_i) : (x_start_i > x_end_i);

  assign cur_x_o = swap ? x_end_i : x_start_i;
  assign cur_y_o = swap ? y_end_i : y_start_i;

  always_comb begin
    if (steep_o) begin
      major_end_o   = swap ? y_start_i : y_end_i;
      major_delta_o = ady;
      minor_delta_o = adx;
      minor_down_o  = swap ? dx_pos : dx_neg;
    end else begin
      major_end_o   = swap ? x_start_i : x_end_i;
      major_delta_o = adx;
      minor_delta_o = ady;
      minor_down_o  = swap ? dy_pos : dy_neg;
    end
  end

  assign err_o = $signed({2'b00, minor_delta_o, 1'b0}) - $signed({3'b000, major_delta_o});

endmodule

// ----- sv/lrast_step.sv -----
// ----------------------------------------------------------------------------
// Line step
// Advances one unit along the major axis and updates the error term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrast_step import lrast_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  input  logic signed [COORD_BITS+3:0] err_i,
  input  logic        [COORD_BITS:0]   major_delta_i,
  input  logic        [COORD_BITS:0]   minor_delta_i,
  input  lrast_ctrl_t                  ctrl_i,
  output logic signed [COORD_BITS-1:0] cur_x_o,
  output logic signed [COORD_BITS-1:0] cur_y_o,
  output logic signed [COORD_BITS+3:0] err_o
);

  localparam int EW = COORD_BITS + 4;
  localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic                          err_pos;
  logic signed [COORD_BITS-1:0]  minor_cur, minor_nxt, major_cur, major_nxt;
  logic signed [EW-1:0]          two_minor, two_major;

  assign err_pos   = !err_i[EW-1] && (err_i != '0);
  assign two_minor = $signed({2'b00, minor_delta_i, 1'b0});
  assign two_major = $signed({2'b00, major_delta_i, 1'b0});

  assign minor_cur = ctrl_i.steep ? cur_x_i : cur_y_i;
  assign major_cur = ctrl_i.steep ? cur_y_i : cur_x_i;
  assign major_nxt = major_cur + ONE;

  always_comb begin
    if (err_pos) begin
      minor_nxt = ctrl_i.minor_down ? (minor_cur - ONE) : (minor_cur + ONE);
      err_o     = err_i + (two_minor - two_major);
    end else begin
      minor_nxt = minor_cur;
      err_o     = err_i + two_minor;
    end
  end

  assign cur_x_o = ctrl_i.steep ? minor_nxt : major_nxt;
  assign cur_y_o = ctrl_i.steep ? major_nxt : minor_nxt;

endmodule

// ----- sv/lrast_emit.sv -----
// ----------------------------------------------------------------------------
// Pixel flags
// Clip window test and end-of-line detection for one pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrast_emit import lrast_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  input  logic signed [COORD_BITS-1:0] major_end_i,
  input  logic                         steep_i,
  input  logic        [CLIP_BITS-1:0]  clip_width_i,
  input  logic        [CLIP_BITS-1:0]  clip_height_i,
  output logic                         visible_o,
  output logic                         last_o
);

  localparam int CW = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;

  logic signed [CW-1:0]         sx, sy, cw, ch;
  logic signed [COORD_BITS-1:0] maj;

  assign sx = CW'(cur_x_i);
  assign sy = CW'(cur_y_i);
  assign cw = $signed({{(CW-CLIP_BITS){1'b0}}, clip_width_i});
  assign ch = $signed({{(CW-CLIP_BITS){1'b0}}, clip_height_i});

  assign visible_o = (sx > 0) && (sx < cw) && (sy > 0) && (sy < ch);

  assign maj    = steep_i ? cur_y_i : cur_x_i;
  assign last_o = (maj >= major_end_i);

endmodule

// ----- sv/lrast_checker.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer checker
// Port-level properties of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_rasterizer_defines.svh"

module lrast_checker import lrast_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_tready_o,
  input logic                              m_tvalid_o,
  input logic                              m_tready_i,
  input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata_o,
  input logic [1:0]                        m_tuser_o,
  input logic                              m_tlast_o
);

  // an empty result stage never blocks the input
  `LRAST_ASSERT_SAME(a_ready_when_empty, !m_tvalid_o, s_tready_o)

  // stalled word holds
  `LRAST_ASSERT_NEXT(a_stall_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o))

  // end of line only on a real pixel
  `LRAST_ASSERT_SAME(a_last_is_pixel, m_tvalid_o && m_tlast_o, m_tuser_o[0])

  // no-pixel word carries all zero fields
  `LRAST_ASSERT_SAME(a_empty_zero, m_tvalid_o && !m_tuser_o[0],
    !m_tuser_o[1] && !m_tlast_o && (m_tdata_o == '0))

endmodule

bind line_rasterizer lrast_checker #(.COORD_BITS(COORD_BITS)) u_lrast_checker (.*);

// ----- dv/line_rasterizer_test.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives start and step commands through the slave stream and walks every
// line in a local Bresenham tracker. Each pixel word on the master stream is
// compared field by field against the oldest predicted pixel. The clip window
// is swept over zero, minimum, maximum, reset, small and random settings;
// both sides insert random gaps and stalls except under the maximum setting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer_test;
  import lrast_pkg::*;

  localparam int CB     = COORD_BITS_DEF;
  localparam int S_BITS = ((4*CB+7)/8)*8;
  localparam int M_BITS = ((2*CB+7)/8)*8;
  localparam int C_MAX  = 32767;
  localparam int C_MIN  = -32768;

  typedef struct packed {
    logic              valid;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic              vis;
    logic              fin;
  } pixel_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_tvalid_i;
  logic                    s_tready_o;
  logic [S_BITS-1:0]       s_tdata_i;   // x_start, y_start, x_end, y_end
  logic                    s_tuser_i;   // func
  logic                    m_tvalid_o;
  logic                    m_tready_i;
  logic [M_BITS-1:0]       m_tdata_o;   // pixel_x, pixel_y
  logic [1:0]              m_tuser_o;   // pixel_valid, visible
  logic                    m_tlast_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CLIP_BITS-1:0]    cfg_data_i;

  line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // tracker state
  logic [CLIP_BITS-1:0] clip_w;
  logic [CLIP_BITS-1:0] clip_h;
  logic signed [15:0]   walk_x;
  logic signed [15:0]   walk_y;
  logic signed [15:0]   walk_end;
  logic signed [19:0]   walk_err;
  logic [16:0]          walk_major;
  logic [16:0]          walk_minor;
  logic                 walk_dn;
  logic                 walk_steep;
  logic                 walk_busy;

  pixel_t pending_pixels[$];
  pixel_t head_pixel;

  int  fail_count;
  int  items_sent;
  int  starts_sent;
  int  pixels_checked;
  int  clip_settings;
  bit  idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic pixel_t trace_pixel(input logic func, input logic [S_BITS-1:0] data);
    pixel_t px;
    int x0, y0, x1, y1, t, adx, ady, dmaj, dmin, e, maj, cx, cy, cw, ch;
    logic signed [15:0] s0, s1, s2, s3;
    px = '0;
    if (func == FUNC_START) begin
      s0 = data[15:0];
      s1 = data[31:16];
      s2 = data[47:32];
      s3 = data[63:48];
      x0 = s0;
      y0 = s1;
      x1 = s2;
      y1 = s3;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      walk_steep = !(ady < adx);
      if (walk_steep ? (y0 > y1) : (x0 > x1)) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      walk_x = 16'(x0);
      walk_y = 16'(y0);
      if (walk_steep) begin
        dmaj = y1 - y0;
        dmin = adx;
        walk_dn = x1 < x0;
        walk_end = 16'(y1);
      end else begin
        dmaj = x1 - x0;
        dmin = ady;
        walk_dn = y1 < y0;
        walk_end = 16'(x1);
      end
      walk_major = 17'(dmaj);
      walk_minor = 17'(dmin);
      walk_err = 20'(2 * dmin - dmaj);
    end else if (!walk_busy) begin
      return px;
    end else begin
      e = walk_err;
      dmaj = walk_major;
      dmin = walk_minor;
      if (e > 0) begin
        if (walk_steep) begin
          walk_x = walk_dn ? walk_x - 16'sd1 : walk_x + 16'sd1;
        end else begin
          walk_y = walk_dn ? walk_y - 16'sd1 : walk_y + 16'sd1;
        end
        e = e + 2 * (dmin - dmaj);
      end else begin
        e = e + 2 * dmin;
      end
      if (walk_steep) begin
        walk_y = walk_y + 16'sd1;
      end else begin
        walk_x = walk_x + 16'sd1;
      end
      walk_err = 20'(e);
    end
    cx = walk_x;
    cy = walk_y;
    cw = clip_w;
    ch = clip_h;
    maj = walk_steep ? cy : cx;
    px.valid = 1'b1;
    px.x = walk_x;
    px.y = walk_y;
    px.vis = cx > 0 && cx < cw && cy > 0 && cy < ch;
    px.fin = maj >= int'(walk_end);
    walk_busy = !px.fin;
    return px;
  endfunction

  function automatic logic [S_BITS-1:0] pack_ends(input int x0, y0, x1, y1);
    return {16'(y1), 16'(x1), 16'(y0), 16'(x0)};
  endfunction

  function automatic int clamp_coord(input int v);
    return (v > C_MAX) ? C_MAX : (v < C_MIN) ? C_MIN : v;
  endfunction

  function automatic int nudge(input int base, input int reach);
    return clamp_coord(base + int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls on the master side
  initial begin
    m_tready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready_i = 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
    end
  end

  // pixel checker
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d", $signed(m_tdata_o[15:0]),
               $signed(m_tdata_o[31:16]));
        fail_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        pixels_checked++;
        if (m_tuser_o[0] !== head_pixel.valid) begin
          $error("pixel_valid expected %0d got %0d", head_pixel.valid, m_tuser_o[0]);
          fail_count++;
        end
        if (m_tdata_o[15:0] !== head_pixel.x) begin
          $error("pixel_x expected %0d got %0d", head_pixel.x, $signed(m_tdata_o[15:0]));
          fail_count++;
        end
        if (m_tdata_o[31:16] !== head_pixel.y) begin
          $error("pixel_y expected %0d got %0d", head_pixel.y, $signed(m_tdata_o[31:16]));
          fail_count++;
        end
        if (m_tuser_o[1] !== head_pixel.vis) begin
          $error("visible expected %0d got %0d", head_pixel.vis, m_tuser_o[1]);
          fail_count++;
        end
        if (m_tlast_o !== head_pixel.fin) begin
          $error("last expected %0d got %0d", head_pixel.fin, m_tlast_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_cmd(input logic func, input logic [S_BITS-1:0] data);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tuser_i = func;
    s_tdata_i = data;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    pending_pixels.push_back(trace_pixel(func, data));
    items_sent++;
    if (func == FUNC_START) starts_sent++;
  endtask

  task automatic send_start(input int x0, y0, x1, y1);
    send_cmd(FUNC_START, pack_ends(x0, y0, x1, y1));
  endtask

  task automatic send_step();
    send_cmd(FUNC_STEP, {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_clip(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = CLIP_BITS'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_CLIP_WIDTH) clip_w = CLIP_BITS'(value);
    else clip_h = CLIP_BITS'(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_idle_step();
    send_step();
  endtask

  task automatic test_single_point();
    send_start(1, 1, 1, 1);
    send_step();
  endtask

  task automatic test_octants();
    send_start(10, 10, 12, 11);
    send_step();
    send_step();
    send_start(20, 22, 21, 20);
    send_step();
    send_step();
    send_start(32, 30, 30, 31);
    send_step();
    send_step();
    send_start(40, 40, 42, 42);
    send_step();
    send_step();
  endtask

  task automatic test_abandon();
    send_start(1598, 898, 1700, 950);
    send_step();
    send_start(0, 0, 0, 0);
  endtask

  task automatic test_coord_extremes();
    send_start(C_MIN, C_MIN, C_MAX, C_MAX);
    send_step();
    send_start(C_MAX, C_MAX - 1, C_MAX - 2, C_MAX);
    send_step();
    send_step();
  endtask

  // random lines, mostly around the current clip window
  task automatic run_lines(input int n_items);
    int stop_at, x0, y0, reach, r;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_cmd(FUNC_START, {$urandom, $urandom});
        repeat ($urandom_range(0, 3)) send_step();
      end else if (r < 12) begin
        send_step();
      end else begin
        reach = ($urandom_range(0, 9) == 0) ? 300 : 12;
        x0 = clamp_coord(int'($urandom_range(0, int'(clip_w) + 16)) - 8);
        y0 = clamp_coord(int'($urandom_range(0, int'(clip_h) + 16)) - 8);
        send_start(x0, y0, nudge(x0, reach), nudge(y0, reach));
        while (walk_busy) begin
          if ($urandom_range(0, 99) < 2) break;
          send_step();
        end
        if ($urandom_range(0, 4) == 0) send_step();
      end
    end
  endtask

  task automatic test_clip_sweep();
    int widths[7];
    int heights[7];
    widths  = '{1600, 1, 0, 32767, 12, 0, 0};
    heights = '{900, 1, 0, 32767, 9, 0, 0};
    widths[5]  = $urandom_range(1, 32767);
    heights[5] = $urandom_range(1, 32767);
    widths[6]  = $urandom_range(1, 64);
    heights[6] = $urandom_range(1, 64);
    foreach (widths[i]) begin
      write_clip(CFG_CLIP_WIDTH, widths[i]);
      write_clip(CFG_CLIP_HEIGHT, heights[i]);
      clip_settings++;
      idle_on = (i != 3);
      run_lines(275);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    s_tuser_i = FUNC_START;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CLIP_WIDTH;
    cfg_data_i = '0;
    clip_w = CLIP_W_RESET;
    clip_h = CLIP_H_RESET;
    walk_x = '0;
    walk_y = '0;
    walk_end = '0;
    walk_err = '0;
    walk_major = '0;
    walk_minor = '0;
    walk_dn = 1'b0;
    walk_steep = 1'b0;
    walk_busy = 1'b0;
    fail_count = 0;
    items_sent = 0;
    starts_sent = 0;
    pixels_checked = 0;
    clip_settings = 1;
    idle_on = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_step();
    test_single_point();
    test_octants();
    test_abandon();
    test_coord_extremes();
    test_clip_sweep();

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d commands (%0d line starts) over %0d clip windows, %0d pixels checked",
             items_sent, starts_sent, clip_settings, pixels_checked);
    $display("Covered all octants, single points, abandoned lines and coordinate extremes");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
